// ----- rtl/gspd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspd_pkg
// Shared types and constants of the gauge stepper position driver.
// ----------------------------------------------------------------------------
package gspd_pkg;

    localparam int TARGET_BITS  = 10;
    localparam int CUR_BITS     = 10;
    localparam int STEP_PER_BITS = 16;
    localparam int MAX_STEP_BITS = 10;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int PHASE_BITS    = 3;

    localparam logic [PHASE_BITS-1:0] PHASE_LAST = 3'd5;

    // coil drive patterns, bit i is the level at phase i
    localparam logic [5:0] COIL_PAT_A = 6'b110001;
    localparam logic [5:0] COIL_PAT_B = 6'b011100;
    localparam logic [5:0] COIL_PAT_D = 6'b000111;

    localparam logic [STEP_PER_BITS-1:0] STEP_PERIOD_RST = 16'd1200;
    localparam logic [MAX_STEP_BITS-1:0] MAX_STEPS_RST   = 10'd960;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_STEP_PERIOD = 1'b0,
        REG_MAX_STEPS   = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        FUNC_TICK       = 1'b0,
        FUNC_SET_TARGET = 1'b1
    } t_func;

    typedef struct packed {
        logic                coil_a;
        logic                coil_b;
        logic                coil_c;
        logic                coil_d;
        logic [CUR_BITS-1:0] current_steps;
        logic                at_target;
        logic                step_taken;
    } t_result;

endpackage

// ----- rtl/gspd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspd_in_if / gspd_out_if
// Valid/ready channels carrying command words in and result words out.
// ----------------------------------------------------------------------------
interface gspd_in_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [gspd_pkg::TARGET_BITS-1:0] target_steps;

    modport source (output valid, output func, output target_steps, input ready);
    modport sink   (input valid, input func, input target_steps, output ready);
endinterface

interface gspd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          coil_a;
    logic                          coil_b;
    logic                          coil_c;
    logic                          coil_d;
    logic [gspd_pkg::CUR_BITS-1:0] current_steps;
    logic                          at_target;
    logic                          step_taken;

    modport source (output valid, output coil_a, output coil_b, output coil_c,
                    output coil_d, output current_steps, output at_target,
                    output step_taken, input ready);
    modport sink   (input valid, input coil_a, input coil_b, input coil_c,
                    input coil_d, input current_steps, input at_target,
                    input step_taken, output ready);
endinterface

// ----- rtl/gauge_stepper_position_driver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauge_stepper_position_driver_unit
// Moves a gauge stepper one step at a time toward a target, paced by ticks.
// ----------------------------------------------------------------------------
// Each input word is either a timer tick or a new target. One result word
// comes out per input word, registered in the cycle after acceptance, and a
// new word is taken every clock as long as the result register is empty or
// being drained in the same cycle: throughput is one word per cycle. The
// tick counter increment, the period compare and the one-step position update
// sit between the state registers and the result register. The coil levels
// follow a six-phase pattern kept in a wrapping phase register.

module gauge_stepper_position_driver_unit #(
    parameter int POSITION_BITS = 10,
    parameter int PERIOD_BITS   = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [gspd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [gspd_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    gspd_in_if.sink                            i_in,
    gspd_out_if.source                         o_res
);

    localparam int CMP_BITS = (PERIOD_BITS > gspd_pkg::STEP_PER_BITS) ?
                              PERIOD_BITS : gspd_pkg::STEP_PER_BITS;

    logic [gspd_pkg::STEP_PER_BITS-1:0] r_step_period;
    logic [gspd_pkg::MAX_STEP_BITS-1:0] r_max_steps;
    logic [POSITION_BITS-1:0]           r_pos,     n_pos;
    logic [POSITION_BITS-1:0]           r_target,  n_target;
    logic [PERIOD_BITS-1:0]             r_elapsed, n_elapsed;
    logic [gspd_pkg::PHASE_BITS-1:0]    r_phase,   n_phase;
    logic                               r_out_vld;
    gspd_pkg::t_result                  r_res,     n_res;

    logic                               in_acc;
    logic [PERIOD_BITS-1:0]             el_inc;
    logic                               reached;
    logic                               moved;
    logic [gspd_pkg::TARGET_BITS-1:0]   sat_req;

    assign i_in.ready = !r_out_vld || o_res.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= gspd_pkg::STEP_PERIOD_RST;
            r_max_steps   <= gspd_pkg::MAX_STEPS_RST;
        end else if (i_cfg_wen) begin
            case (gspd_pkg::t_cfg_idx'(i_cfg_idx))
                gspd_pkg::REG_STEP_PERIOD: begin
                    r_step_period <= i_cfg_wdata[gspd_pkg::STEP_PER_BITS-1:0];
                end
                gspd_pkg::REG_MAX_STEPS: begin
                    r_max_steps <= i_cfg_wdata[gspd_pkg::MAX_STEP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // next state and result
    always_comb begin
        n_pos     = r_pos;
        n_target  = r_target;
        n_elapsed = r_elapsed;
        n_phase   = r_phase;
        moved     = 1'b0;
        el_inc    = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;
        reached   = CMP_BITS'(el_inc) >= CMP_BITS'(r_step_period);
        sat_req   = (i_in.target_steps > r_max_steps) ? r_max_steps : i_in.target_steps;

        if (gspd_pkg::t_func'(i_in.func) == gspd_pkg::FUNC_SET_TARGET) begin
            n_target = POSITION_BITS'(sat_req);
        end else begin
            n_elapsed = el_inc;
            if (reached) begin
                n_elapsed = '0;
                if (r_target > r_pos) begin
                    n_pos   = r_pos + 1'b1;
                    n_phase = (r_phase >= gspd_pkg::PHASE_LAST) ? '0 : r_phase + 1'b1;
                    moved   = 1'b1;
                end else if (r_target < r_pos) begin
                    n_pos   = r_pos - 1'b1;
                    n_phase = (r_phase == '0 || r_phase > gspd_pkg::PHASE_LAST) ?
                              gspd_pkg::PHASE_LAST : r_phase - 1'b1;
                    moved   = 1'b1;
                end
            end
        end

        n_res.coil_a        = 1'b0;
        n_res.coil_b        = 1'b0;
        n_res.coil_c        = 1'b0;
        n_res.coil_d        = 1'b0;
        if (n_phase <= gspd_pkg::PHASE_LAST) begin
            n_res.coil_a = gspd_pkg::COIL_PAT_A[n_phase];
            n_res.coil_b = gspd_pkg::COIL_PAT_B[n_phase];
            n_res.coil_c = gspd_pkg::COIL_PAT_B[n_phase];
            n_res.coil_d = gspd_pkg::COIL_PAT_D[n_phase];
        end else begin
            n_res.coil_a = gspd_pkg::COIL_PAT_A[0];
            n_res.coil_b = gspd_pkg::COIL_PAT_B[0];
            n_res.coil_c = gspd_pkg::COIL_PAT_B[0];
            n_res.coil_d = gspd_pkg::COIL_PAT_D[0];
        end
        n_res.current_steps = gspd_pkg::CUR_BITS'(n_pos);
        n_res.at_target     = (n_pos == n_target);
        n_res.step_taken    = moved;
    end

    // motor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_target  <= '0;
            r_elapsed <= '1;
            r_phase   <= '0;
        end else if (in_acc) begin
            r_pos     <= n_pos;
            r_target  <= n_target;
            r_elapsed <= n_elapsed;
            r_phase   <= n_phase;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_acc) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.coil_a        = r_res.coil_a;
    assign o_res.coil_b        = r_res.coil_b;
    assign o_res.coil_c        = r_res.coil_c;
    assign o_res.coil_d        = r_res.coil_d;
    assign o_res.current_steps = r_res.current_steps;
    assign o_res.at_target     = r_res.at_target;
    assign o_res.step_taken    = r_res.step_taken;

`ifndef SYNTH
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= gspd_pkg::PHASE_LAST)
        else $error("phase out of range");

    a_set_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.func |=> !r_res.step_taken && $stable(r_pos))
        else $error("set-target word moved the pointer");

    a_pos_moves_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in.func && n_pos != r_pos |=> r_res.step_taken && r_elapsed == '0)
        else $error("step without counter restart");

    a_res_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_vld)
        else $error("accepted word produced no result");
`endif

endmodule
